@@ rtl/satt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// satt_pkg
// Types, codes and score arithmetic shared by the transposition table.
// ----------------------------------------------------------------------------
package satt_pkg;

	localparam logic       REQ_LOOKUP = 1'b0;
	localparam logic       REQ_STORE  = 1'b1;

	localparam logic       CFG_TABLE_ENABLE   = 1'b0;
	localparam logic       CFG_MATE_THRESHOLD = 1'b1;
	localparam int         CFG_DATA_W         = 15;

	localparam logic       TABLE_ENABLE_RST   = 1'b1;
	localparam logic [14:0] MATE_THRESHOLD_RST = 15'd31000;

	localparam logic [7:0] EMPTY_DEPTH = 8'hFF;
	localparam int         INFO_W      = 26;
	// score, eval, move and info next to the tag
	localparam int         ENT_DATA_W  = 16 + 16 + 16 + INFO_W;

	typedef enum logic [2:0] {
		OC_LOOKUP          = 3'd0,
		OC_FILL_EMPTY      = 3'd1,
		OC_REPLACE_STALE   = 3'd2,
		OC_UPDATE          = 3'd3,
		OC_UPDATE_BLOCKED  = 3'd4,
		OC_REPLACE_SCORE   = 3'd5,
		OC_REPLACE_BLOCKED = 3'd6
	} outcome_t;

	typedef struct packed {
		logic               req_type;
		logic [63:0]        key;
		logic [7:0]         ply;
		logic signed [15:0] score;
		logic signed [15:0] static_eval;
		logic [15:0]        best_move;
		logic [7:0]         depth;
		logic [1:0]         bound_flag;
		logic [7:0]         generation;
		logic [7:0]         nonrev_count;
		logic [7:0]         root_nonrev_count;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic signed [15:0] out_score;
		logic signed [15:0] out_static_eval;
		logic [15:0]        out_move;
		logic [7:0]         out_depth;
		logic [1:0]         out_flag;
		logic [7:0]         out_generation;
		logic [7:0]         out_nonrev;
		logic [2:0]         store_outcome;
	} rsp_t;

	// Mate-like scores move by ply: away from the root on store, toward it
	// on lookup. Zero counts as non-positive.
	function automatic logic signed [15:0] adjust_score(
		input logic signed [15:0] v,
		input logic [7:0]         ply,
		input logic [14:0]        thr,
		input logic               away
	);
		logic signed [16:0] v17;
		logic signed [16:0] mag;
		logic signed [16:0] p17;
		logic signed [16:0] sum;
		logic               up;
		v17 = {v[15], v};
		p17 = {9'b0, ply};
		mag = v17[16] ? -v17 : v17;
		if (mag < $signed({2'b00, thr})) begin
			return v;
		end
		up  = ((v17 > 17'sd0) == away);
		sum = up ? (v17 + p17) : (v17 - p17);
		if (sum > 17'sd32767) begin
			return 16'sh7FFF;
		end
		if (sum < -17'sd32768) begin
			return 16'sh8000;
		end
		return sum[15:0];
	endfunction

endpackage

@@ rtl/set_assoc_transposition_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_transposition_table
// Set-associative search-result table with lookup, store and replacement.
// ----------------------------------------------------------------------------
// One request at a time. Each cluster is one row of a single-port-style
// synchronous RAM (one read or one write per cycle). With a power-of-two
// CLUSTERS the accept cycle issues the row read, and the evaluate state then
// picks the way, writes the row back and loads the response register.
// Otherwise the cluster index (key mod CLUSTERS) comes from a remainder unit
// that consumes four key bits per cycle before the evaluate state. A new
// request is taken while the previous response still waits on rsp_ready;
// the evaluate cycle holds until the response register frees.
// After reset the table sweeps all CLUSTERS rows to mark them empty, one row
// per cycle, with req_ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module set_assoc_transposition_table #(
	parameter int CLUSTERS = 1024,
	parameter int WAYS     = 4,
	parameter int TAG_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  satt_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output satt_pkg::rsp_t               rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [satt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import satt_pkg::*;

	localparam int  IDX_W   = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
	localparam int  REM_W   = IDX_W + 1;
	localparam int  WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int  ENT_W   = TAG_BITS + ENT_DATA_W;
	localparam int  ROW_W   = WAYS * ENT_W;
	localparam bit  IS_POW2 = ((CLUSTERS & (CLUSTERS - 1)) == 0);
	localparam logic [ENT_W-1:0] EMPTY_ENT =
		ENT_W'({{(INFO_W-8){1'b0}}, EMPTY_DEPTH}) << (TAG_BITS + 48);
	localparam logic [ROW_W-1:0] EMPTY_ROW = {WAYS{EMPTY_ENT}};
	localparam logic [IDX_W-1:0] LAST_ROW  = IDX_W'(CLUSTERS - 1);
	localparam logic [REM_W-1:0] MODULUS   = REM_W'(CLUSTERS);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_EVAL
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   clr_q;
	logic [IDX_W-1:0]   clus_q;
	logic [REM_W-1:0]   rem_q;
	logic [63:0]        keysh_q;
	logic [3:0]         cnt_q;
	req_t               req_q;
	logic signed [15:0] st_score_q;
	logic signed [15:0] st_eval_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               table_enable_q;
	logic [14:0]        mate_threshold_q;

	logic [ROW_W-1:0]   mem [CLUSTERS];
	logic [ROW_W-1:0]   rd_row_q;
	logic               mem_re;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_raddr;
	logic [IDX_W-1:0]   mem_waddr;
	logic [ROW_W-1:0]   mem_wdata;

	logic               req_fire;
	logic               eval_go;
	logic [IDX_W-1:0]   cluster_direct;
	logic [REM_W-1:0]   rem_next;

	logic [ENT_W-1:0]   ent [WAYS];
	logic               ent_empty [WAYS];
	logic [7:0]         ent_depth [WAYS];
	logic [7:0]         ent_gen [WAYS];
	logic [7:0]         ent_nonrev [WAYS];
	logic [ENT_W-1:0]   sel_ent;
	logic               mt_found;
	logic [WAY_W-1:0]   mt_way;
	logic               es_found;
	logic               es_empty;
	logic [WAY_W-1:0]   es_way;
	logic               rp_found;
	logic [WAY_W-1:0]   rp_way;
	logic signed [7:0]  rp_best;
	logic signed [7:0]  rp_sc;
	logic [WAY_W-1:0]   tgt_way;
	logic               wr_hit;
	outcome_t           outcome;
	logic [ENT_W-1:0]   new_ent;
	logic [ROW_W-1:0]   wr_row;
	rsp_t               rsp_n;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign eval_go   = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	assign cluster_direct = (CLUSTERS == 1) ? '0 : req.key[IDX_W-1:0];

	// four restoring steps of the remainder, MSB first
	always_comb begin
		logic [REM_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < 4; i++) begin
			r = {r[REM_W-2:0], keysh_q[63-i]};
			if (r >= MODULUS) begin
				r = r - MODULUS;
			end
		end
		rem_next = r;
	end

	// way decode of the row just read
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			ent[w]        = rd_row_q[w*ENT_W +: ENT_W];
			ent_depth[w]  = ent[w][TAG_BITS+48 +: 8];
			ent_gen[w]    = ent[w][TAG_BITS+58 +: 8];
			ent_nonrev[w] = ent[w][TAG_BITS+66 +: 8];
			ent_empty[w]  = (ent_depth[w] == EMPTY_DEPTH);
		end
	end

	always_comb begin
		mt_found = 1'b0;
		mt_way   = '0;
		es_found = 1'b0;
		es_empty = 1'b0;
		es_way   = '0;
		rp_found = 1'b0;
		rp_way   = '0;
		rp_best  = 8'sd0;
		rp_sc    = 8'sd0;
		for (int w = 0; w < WAYS; w++) begin
			if (!mt_found && !ent_empty[w] &&
			    ent[w][TAG_BITS-1:0] == req_q.key[TAG_BITS-1:0]) begin
				mt_found = 1'b1;
				mt_way   = WAY_W'(w);
			end
			if (!es_found && (ent_empty[w] ||
			    ent_nonrev[w] < req_q.root_nonrev_count)) begin
				es_found = 1'b1;
				es_empty = ent_empty[w];
				es_way   = WAY_W'(w);
			end
			// int8 wrap of depth gain plus generation gain
			rp_sc = $signed(8'(req_q.depth - ent_depth[w] + req_q.generation - ent_gen[w]));
			if (rp_sc > rp_best) begin
				rp_best  = rp_sc;
				rp_found = 1'b1;
				rp_way   = WAY_W'(w);
			end
		end
	end

	assign sel_ent = ent[mt_way];

	always_comb begin
		outcome = OC_LOOKUP;
		wr_hit  = 1'b0;
		tgt_way = '0;
		rsp_n   = '0;
		if (table_enable_q) begin
			if (req_q.req_type == REQ_LOOKUP) begin
				if (mt_found) begin
					rsp_n.hit             = 1'b1;
					rsp_n.out_score       = adjust_score(sel_ent[TAG_BITS +: 16],
						req_q.ply, mate_threshold_q, 1'b0);
					rsp_n.out_static_eval = adjust_score(sel_ent[TAG_BITS+16 +: 16],
						req_q.ply, mate_threshold_q, 1'b0);
					rsp_n.out_move        = sel_ent[TAG_BITS+32 +: 16];
					rsp_n.out_depth       = sel_ent[TAG_BITS+48 +: 8];
					rsp_n.out_flag        = sel_ent[TAG_BITS+56 +: 2];
					rsp_n.out_generation  = sel_ent[TAG_BITS+58 +: 8];
					rsp_n.out_nonrev      = sel_ent[TAG_BITS+66 +: 8];
				end
			end else begin
				if (mt_found) begin
					tgt_way = mt_way;
					if (ent_depth[mt_way] < req_q.depth) begin
						outcome = OC_UPDATE;
						wr_hit  = 1'b1;
					end else begin
						outcome = OC_UPDATE_BLOCKED;
					end
				end else if (es_found) begin
					tgt_way = es_way;
					wr_hit  = 1'b1;
					outcome = es_empty ? OC_FILL_EMPTY : OC_REPLACE_STALE;
				end else if (rp_found) begin
					tgt_way = rp_way;
					wr_hit  = 1'b1;
					outcome = OC_REPLACE_SCORE;
				end else begin
					outcome = OC_REPLACE_BLOCKED;
				end
				rsp_n.store_outcome = outcome;
			end
		end
	end

	always_comb begin
		new_ent = {req_q.nonrev_count, req_q.generation, req_q.bound_flag, req_q.depth,
			req_q.best_move, st_eval_q, st_score_q, req_q.key[TAG_BITS-1:0]};
		wr_row  = rd_row_q;
		wr_row[tgt_way*ENT_W +: ENT_W] = new_ent;
	end

	always_comb begin
		mem_re    = (state_q == ST_IDLE && req_fire && IS_POW2) ||
		            (state_q == ST_MOD && cnt_q == 4'd15);
		mem_raddr = (state_q == ST_IDLE) ? cluster_direct : rem_next[IDX_W-1:0];
		mem_we    = (state_q == ST_CLEAR) || (state_q == ST_EVAL && eval_go && wr_hit);
		mem_waddr = (state_q == ST_CLEAR) ? clr_q : clus_q;
		mem_wdata = (state_q == ST_CLEAR) ? EMPTY_ROW : wr_row;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_row_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_enable_q   <= TABLE_ENABLE_RST;
			mate_threshold_q <= MATE_THRESHOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TABLE_ENABLE:   table_enable_q   <= cfg_data[0];
				CFG_MATE_THRESHOLD: mate_threshold_q <= cfg_data[14:0];
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			clus_q      <= '0;
			rem_q       <= '0;
			keysh_q     <= '0;
			cnt_q       <= '0;
			req_q       <= '0;
			st_score_q  <= '0;
			st_eval_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ROW) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						req_q      <= req;
						st_score_q <= adjust_score(req.score, req.ply, mate_threshold_q, 1'b1);
						st_eval_q  <= adjust_score(req.static_eval, req.ply,
							mate_threshold_q, 1'b1);
						clus_q     <= cluster_direct;
						keysh_q    <= req.key;
						rem_q      <= '0;
						cnt_q      <= '0;
						state_q    <= IS_POW2 ? ST_EVAL : ST_MOD;
					end
				end
				ST_MOD: begin
					rem_q   <= rem_next;
					keysh_q <= {keysh_q[59:0], 4'b0};
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == 4'd15) begin
						clus_q  <= rem_next[IDX_W-1:0];
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (eval_go) begin
						rsp_q       <= rsp_n;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_rw_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("row read and write in the same cycle");

	a_rsp_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_EVAL))
		else $error("response loaded outside the evaluate cycle");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q != ST_IDLE)
		else $error("request accepted but no work started");

	a_write_is_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && mem_we) |-> (req_q.req_type == REQ_STORE && table_enable_q))
		else $error("row written without an enabled store");

	a_hit_is_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.hit) |-> rsp_q.store_outcome == OC_LOOKUP)
		else $error("hit reported with a store outcome");

endmodule

@@ bench/tb_set_assoc_transposition_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_transposition_table
// Drives lookups and stores into the transposition table under changing enable
// and mate-threshold settings and random handshake pressure. A mirror of the
// table predicts every response (hit data, mate-score shifts, fill, stale,
// update and replacement decisions) and checks each response beat field by
// field in order.
// ----------------------------------------------------------------------------
module tb_set_assoc_transposition_table;
	import satt_pkg::*;

	localparam int CLUSTERS = 1024;
	localparam int WAYS     = 4;
	localparam int TAG_BITS = 16;
	localparam int SLOTS    = CLUSTERS * WAYS;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_ready;
	rsp_t                  rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// mirror of the table contents and the register file
	class tt_mirror;
		logic [TAG_BITS-1:0] tag_m [SLOTS];
		logic signed [15:0]  score_m [SLOTS];
		logic signed [15:0]  eval_m [SLOTS];
		logic [15:0]         move_m [SLOTS];
		logic [7:0]          depth_m [SLOTS];
		logic [1:0]          flag_m [SLOTS];
		logic [7:0]          gen_m [SLOTS];
		logic [7:0]          nonrev_m [SLOTS];
		bit                  en;
		int                  thr;
		rsp_t                owed_rsp [$];
		int                  fails;
		int                  taken;
		int                  hits;
		int                  misses;
		int                  oc_cnt [8];

		function new();
			int i;
			for (i = 0; i < SLOTS; i++) begin
				tag_m[i]    = '0;
				score_m[i]  = '0;
				eval_m[i]   = '0;
				move_m[i]   = '0;
				depth_m[i]  = EMPTY_DEPTH;
				flag_m[i]   = '0;
				gen_m[i]    = '0;
				nonrev_m[i] = '0;
			end
			for (i = 0; i < 8; i++) oc_cnt[i] = 0;
			en     = TABLE_ENABLE_RST;
			thr    = MATE_THRESHOLD_RST;
			fails  = 0;
			taken  = 0;
			hits   = 0;
			misses = 0;
		endfunction

		function void set_cfg(logic idx, logic [CFG_DATA_W-1:0] d);
			if (idx == CFG_TABLE_ENABLE) en = d[0];
			else thr = d;
		endfunction

		// away=1 pushes a mate score away from the root, away=0 pulls it back
		function logic signed [15:0] mate_shift(logic signed [15:0] v, logic [7:0] ply, bit away);
			int x;
			int mag;
			x = v;
			mag = (x < 0) ? -x : x;
			if (mag < thr) return v;
			if ((x > 0) == away) x = x + ply;
			else x = x - ply;
			if (x > 32767) x = 32767;
			if (x < -32768) x = -32768;
			return x[15:0];
		endfunction

		function void note_req(req_t r);
			rsp_t                e;
			int                  base;
			int                  slot;
			int                  tgt;
			int                  best;
			int                  sc;
			int                  w;
			logic [TAG_BITS-1:0] tg;
			logic [7:0]          diff;
			outcome_t            oc;
			e     = '0;
			base  = int'(r.key % 64'(CLUSTERS)) * WAYS;
			tg    = r.key[TAG_BITS-1:0];
			oc    = OC_LOOKUP;
			tgt   = -1;
			taken++;
			if (en && r.req_type == REQ_LOOKUP) begin
				for (w = 0; w < WAYS; w++) begin
					slot = base + w;
					if (!e.hit && depth_m[slot] != EMPTY_DEPTH && tag_m[slot] == tg) begin
						e.hit             = 1'b1;
						e.out_score       = mate_shift(score_m[slot], r.ply, 1'b0);
						e.out_static_eval = mate_shift(eval_m[slot], r.ply, 1'b0);
						e.out_move        = move_m[slot];
						e.out_depth       = depth_m[slot];
						e.out_flag        = flag_m[slot];
						e.out_generation  = gen_m[slot];
						e.out_nonrev      = nonrev_m[slot];
					end
				end
			end else if (en) begin
				for (w = 0; w < WAYS; w++) begin
					slot = base + w;
					if (oc == OC_LOOKUP && depth_m[slot] != EMPTY_DEPTH && tag_m[slot] == tg) begin
						if (depth_m[slot] < r.depth) begin
							oc  = OC_UPDATE;
							tgt = slot;
						end else begin
							oc = OC_UPDATE_BLOCKED;
						end
					end
				end
				for (w = 0; w < WAYS; w++) begin
					slot = base + w;
					if (oc == OC_LOOKUP) begin
						if (depth_m[slot] == EMPTY_DEPTH) begin
							oc  = OC_FILL_EMPTY;
							tgt = slot;
						end else if (nonrev_m[slot] < r.root_nonrev_count) begin
							oc  = OC_REPLACE_STALE;
							tgt = slot;
						end
					end
				end
				if (oc == OC_LOOKUP) begin
					best = 0;
					for (w = 0; w < WAYS; w++) begin
						slot = base + w;
						// wraps to 8 bits, then read as int8
						diff = r.depth - depth_m[slot] + r.generation - gen_m[slot];
						sc = $signed(diff);
						if (sc > best) begin
							best = sc;
							tgt  = slot;
						end
					end
					oc = (tgt >= 0) ? OC_REPLACE_SCORE : OC_REPLACE_BLOCKED;
				end
				if (tgt >= 0) begin
					tag_m[tgt]    = tg;
					score_m[tgt]  = mate_shift(r.score, r.ply, 1'b1);
					eval_m[tgt]   = mate_shift(r.static_eval, r.ply, 1'b1);
					move_m[tgt]   = r.best_move;
					depth_m[tgt]  = r.depth;
					flag_m[tgt]   = r.bound_flag;
					gen_m[tgt]    = r.generation;
					nonrev_m[tgt] = r.nonrev_count;
				end
				e.store_outcome = oc;
			end
			owed_rsp.push_back(e);
		endfunction

		function void cmp(string nm, logic signed [31:0] want, logic signed [31:0] seen);
			if (want !== seen) begin
				fails++;
				if (fails <= 40)
					$display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, want, seen);
			end
		endfunction

		function void check_rsp(rsp_t g);
			rsp_t e;
			if (owed_rsp.size() == 0) begin
				fails++;
				if (fails <= 40)
					$display("%0t: response beat with none expected, actual %h", $time, g);
				return;
			end
			e = owed_rsp.pop_front();
			cmp("hit", e.hit, g.hit);
			cmp("out_score", e.out_score, g.out_score);
			cmp("out_static_eval", e.out_static_eval, g.out_static_eval);
			cmp("out_move", e.out_move, g.out_move);
			cmp("out_depth", e.out_depth, g.out_depth);
			cmp("out_flag", e.out_flag, g.out_flag);
			cmp("out_generation", e.out_generation, g.out_generation);
			cmp("out_nonrev", e.out_nonrev, g.out_nonrev);
			cmp("store_outcome", e.store_outcome, g.store_outcome);
			if (e.store_outcome != OC_LOOKUP) oc_cnt[e.store_outcome]++;
			else if (e.hit) hits++;
			else misses++;
		endfunction
	endclass

	tt_mirror   mirror;
	int         send_idle;
	int         recv_stall;
	int         hold_left;
	logic [7:0] gen_now;
	logic [5:0] tag_base;
	logic [9:0] cl_pool [8];

	set_assoc_transposition_table #(
		.CLUSTERS(CLUSTERS),
		.WAYS    (WAYS),
		.TAG_BITS(TAG_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [63:0] ckey(logic [5:0] hi, logic [9:0] cl);
		return {48'h5A3C_96E1_0F77, hi, cl};
	endfunction

	function automatic req_t mk_req(logic op, logic [63:0] k, logic [7:0] ply, int sc, int ev,
		logic [15:0] mv, logic [7:0] d, logic [1:0] fl, logic [7:0] g, logic [7:0] nr,
		logic [7:0] root);
		req_t r;
		r.req_type          = op;
		r.key               = k;
		r.ply               = ply;
		r.score             = sc[15:0];
		r.static_eval       = ev[15:0];
		r.best_move         = mv;
		r.depth             = d;
		r.bound_flag        = fl;
		r.generation        = g;
		r.nonrev_count      = nr;
		r.root_nonrev_count = root;
		return r;
	endfunction

	// mix of plain scores, near-mate extremes and values around the threshold
	function automatic logic signed [15:0] pick_score(int thr);
		int v;
		case ($urandom_range(0, 2))
			0: v = int'($urandom_range(0, 65535)) - 32768;
			1: v = 32768 - int'($urandom_range(0, 300));
			default: v = thr + int'($urandom_range(0, 20)) - 10;
		endcase
		if ($urandom_range(0, 1)) v = -v;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic req_t rand_req();
		req_t r;
		int   kind;
		int   d;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom};
		kind = $urandom_range(0, 99);
		if (kind < 90) begin
			// few clusters and few tags so ways collide, match and get replaced
			r.key[15:0]    = {tag_base + 6'($urandom_range(0, 5)), cl_pool[$urandom_range(0, 7)]};
			r.req_type     = (kind < 45) ? REQ_STORE : REQ_LOOKUP;
			r.generation   = gen_now + 8'($urandom_range(0, 3));
			r.score        = pick_score(mirror.thr);
			r.static_eval  = pick_score(mirror.thr);
			d = $urandom_range(0, 199);
			if (d == 0) r.depth = EMPTY_DEPTH;
			else if (d < 160) r.depth = $urandom_range(0, 40);
			else r.depth = $urandom_range(0, 254);
			if ($urandom_range(0, 9) < 7) r.root_nonrev_count = '0;
		end
		return r;
	endfunction

	task automatic send_req(input req_t r);
		while ($urandom_range(0, 99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		mirror.note_req(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (mirror.owed_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic set_table(input bit en, input logic [CFG_DATA_W-1:0] thr);
		logic [CFG_DATA_W-1:0] d0;
		d0    = $urandom;
		d0[0] = en;
		cfg_valid <= 1'b1;
		cfg_index <= CFG_TABLE_ENABLE;
		cfg_data  <= d0;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		mirror.set_cfg(CFG_TABLE_ENABLE, d0);
		cfg_index <= CFG_MATE_THRESHOLD;
		cfg_data  <= thr;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		mirror.set_cfg(CFG_MATE_THRESHOLD, thr);
		cfg_valid <= 1'b0;
	endtask

	// response side: random stalls plus an optional long hold-off
	initial begin
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready === 1'b1) mirror.check_rsp(rsp);
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= recv_stall);
			end
		end
	end

	initial begin
		int                    p;
		int                    i;
		int                    n;
		bit                    en_v;
		logic [CFG_DATA_W-1:0] thr_v;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_TABLE_ENABLE;
		cfg_data  <= '0;
		mirror     = new();
		send_idle  = 0;
		recv_stall = 0;
		hold_left  = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, threshold 31000
		send_req(mk_req(REQ_LOOKUP, ckey(0, 5), 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(mk_req(REQ_STORE, ckey(0, 5), 5, 31500, -31200, 16'h1234, 10, 1, 1, 3, 0));
		send_req(mk_req(REQ_LOOKUP, ckey(0, 5), 3, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(mk_req(REQ_STORE, ckey(0, 5), 0, 7, 7, 16'h0001, 10, 0, 1, 3, 0));
		send_req(mk_req(REQ_STORE, ckey(0, 5), 255, -32768, 32767, 16'hFFFF, 20, 3, 255, 255, 0));
		send_req(mk_req(REQ_LOOKUP, ckey(0, 5), 255, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(mk_req(REQ_STORE, ckey(1, 5), 1, 100, -100, 16'h0101, 0, 2, 0, 3, 0));
		send_req(mk_req(REQ_STORE, ckey(2, 5), 2, 200, -200, 16'h0202, 1, 1, 0, 3, 0));
		send_req(mk_req(REQ_STORE, ckey(3, 5), 3, 300, -300, 16'h0303, 2, 0, 0, 3, 0));
		// way 1 has a low nonrev count against root 100: stale
		send_req(mk_req(REQ_STORE, ckey(4, 5), 4, 31000, -31000, 16'h0404, 30, 1, 1, 7, 100));
		send_req(mk_req(REQ_LOOKUP, ckey(1, 5), 9, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(mk_req(REQ_STORE, ckey(0, 6), 0, 0, 1, 16'h1000, 100, 0, 50, 10, 0));
		send_req(mk_req(REQ_STORE, ckey(1, 6), 0, 0, 2, 16'h1001, 100, 1, 50, 10, 0));
		send_req(mk_req(REQ_STORE, ckey(2, 6), 0, 0, 3, 16'h1002, 100, 2, 50, 10, 0));
		send_req(mk_req(REQ_STORE, ckey(3, 6), 0, 0, 4, 16'h1003, 100, 3, 50, 10, 0));
		// equal depth and generation everywhere: nothing to replace
		send_req(mk_req(REQ_STORE, ckey(4, 6), 0, 0, 5, 16'h1004, 100, 0, 50, 10, 0));
		// one deeper: every way scores 1, first way wins
		send_req(mk_req(REQ_STORE, ckey(5, 6), 0, 0, 6, 16'h1005, 101, 1, 50, 20, 10));
		send_req(mk_req(REQ_STORE, ckey(6, 6), 0, 0, 7, 16'h1006, 100, 2, 50, 10, 11));
		send_req(mk_req(REQ_LOOKUP, ckey(5, 6), 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// depth 255 lands as an empty way
		send_req(mk_req(REQ_STORE, ckey(0, 7), 0, 5, 5, 16'h2000, 255, 1, 9, 9, 0));
		send_req(mk_req(REQ_LOOKUP, ckey(0, 7), 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(mk_req(REQ_STORE, ckey(0, 7), 0, 6, 6, 16'h2001, 254, 2, 9, 9, 0));
		send_req(mk_req(REQ_STORE, '1, 255, 32767, -32768, 16'hFFFF, 254, 3, 255, 255, 255));
		send_req(mk_req(REQ_LOOKUP, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_req(mk_req(REQ_LOOKUP, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		drain();

		for (p = 0; p < 8; p++) begin
			case (p)
				0: begin en_v = 1; thr_v = 31000; send_idle = 0;  recv_stall = 0;  n = 150; end
				1: begin en_v = 1; thr_v = 0;     send_idle = 74; recv_stall = 0;  n = 130; end
				2: begin en_v = 1; thr_v = 32767; send_idle = 0;  recv_stall = 74; n = 130; end
				3: begin en_v = 1; thr_v = 30000; send_idle = 8;  recv_stall = 8;  n = 130; end
				4: begin en_v = 0; thr_v = 1000;  send_idle = 8;  recv_stall = 8;  n = 80;  end
				5: begin en_v = 1; thr_v = 32000; send_idle = 0;  recv_stall = 0;  n = 150; end
				6: begin en_v = 1; thr_v = 31000; send_idle = 74; recv_stall = 74; n = 100; end
				default: begin
					en_v = 1; thr_v = $urandom_range(0, 32767);
					send_idle = 8; recv_stall = 8; n = 155;
				end
			endcase
			set_table(en_v, thr_v);
			gen_now  = $urandom;
			tag_base = $urandom;
			for (i = 0; i < 8; i++) cl_pool[i] = $urandom;
			// long receiver hold-off backs the table up into its input
			if (p == 5) hold_left = 300;
			for (i = 0; i < n; i++) begin
				if (p == 5 && i == n / 2) drain();
				send_req(rand_req());
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Run covered %0d requests over 9 settings (table off, thresholds 0 and 32767): %0d hits, %0d no-hit results",
			mirror.taken, mirror.hits, mirror.misses);
		$display("Stores: fill %0d, stale %0d, update %0d, update blocked %0d, replace %0d, replace blocked %0d",
			mirror.oc_cnt[OC_FILL_EMPTY], mirror.oc_cnt[OC_REPLACE_STALE], mirror.oc_cnt[OC_UPDATE],
			mirror.oc_cnt[OC_UPDATE_BLOCKED], mirror.oc_cnt[OC_REPLACE_SCORE],
			mirror.oc_cnt[OC_REPLACE_BLOCKED]);
		if (mirror.fails == 0 && mirror.owed_rsp.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
